FILE: design/mtt_pkg.sv
// types and constants shared by the timer table
// no dependencies; used by multi_timer_table
package mtt_pkg;

	localparam int REM_W     = 40;
	localparam int RELOAD_W  = 31;
	localparam int ELAPSED_W = 16;

	localparam logic [REM_W-1:0] REM_MIN = {1'b1, {(REM_W-1){1'b0}}};

	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_STOP  = 2'd1;
	localparam logic [1:0] CMD_TICK  = 2'd2;

	localparam logic [1:0] KIND_STATUS = 2'd0;
	localparam logic [1:0] KIND_EXPIRY = 2'd1;
	localparam logic [1:0] KIND_DONE   = 2'd2;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_RUNNING = 2'd1;
	localparam logic [1:0] STATUS_IDLE    = 2'd2;

	typedef struct packed {
		logic [1:0]           cmd;
		logic [3:0]           timer_id;
		logic [RELOAD_W-1:0]  initial_remaining;
		logic [RELOAD_W-1:0]  reload_interval;
		logic                 one_shot;
		logic [ELAPSED_W-1:0] elapsed_ms;
	} item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [1:0] status;
		logic [3:0] expired_id;
		logic [4:0] active_count;
		logic       last;
	} result_t;

endpackage

FILE: design/mtt_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module mtt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: design/multi_timer_table.sv
// timer table top level: command decode, tick sequencer and expiry datapath
// depends on mtt_pkg and mtt_ram
//
// Start, stop and unused commands are taken when busy is low and give one
// status word on the following cycle; a new command may follow at once. A tick
// walks the table one entry per cycle through the ram read port and a shared
// subtract/reload unit, holds busy high while it runs and
// gives one expiry word per expired timer in id order, then a closing word with
// the active count. Words appear for exactly one cycle with strobe high and
// must be taken then; at most one word appears per cycle.
module multi_timer_table #(
	parameter int NUM_TIMERS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  mtt_pkg::item_t   item,
	output logic             strobe,
	output mtt_pkg::result_t result
);

	import mtt_pkg::*;

	localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int CW = ($clog2(NUM_TIMERS + 1) > 5) ? $clog2(NUM_TIMERS + 1) : 5;
	localparam int RW = REM_W + RELOAD_W;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_TICK = 2'b10
	} state_t;

	state_t                state_q;
	logic                  issue_q;
	logic [IW-1:0]         rd_idx_q;
	logic [ELAPSED_W-1:0]  elapsed_q;
	logic                  v_s1;
	logic [IW-1:0]         idx_s1;
	logic                  v_s2;
	logic [IW-1:0]         idx_s2;
	logic [REM_W-1:0]      rem_s2;
	logic [RELOAD_W-1:0]   reload_s2;
	logic [NUM_TIMERS-1:0] running_q;
	logic [NUM_TIMERS-1:0] oneshot_q;
	logic [CW-1:0]         cnt_q;
	logic                  strobe_q;
	result_t               res_q;

	logic                  accept;
	logic [IW+3:0]         id_wide;
	logic [IW-1:0]         id_addr;
	logic                  id_ok;
	logic [1:0]            cmd_status;
	logic                  set_run;
	logic                  clr_run;
	logic [CW-1:0]         cnt_cmd;

	logic                  ram_we;
	logic [IW-1:0]         ram_waddr;
	logic [RW-1:0]         ram_wdata;
	logic [RW-1:0]         ram_rdata;

	logic [REM_W-1:0]      rem_s1;
	logic [RELOAD_W-1:0]   reload_s1;
	logic [REM_W:0]        diff_s1;
	logic [REM_W-1:0]      sat_s1;

	logic                  neg_s2;
	logic [REM_W-1:0]      sum_s2;
	logic [REM_W-1:0]      new_rem_s2;
	logic                  live_s2;
	logic                  expire_s2;
	logic                  drop_s2;
	logic [CW-1:0]         cnt_drop;
	logic [IW+3:0]         xid_wide;
	logic                  closing;

	assign accept  = start && (state_q == ST_IDLE);
	assign busy    = (state_q != ST_IDLE);
	assign id_wide = {{IW{1'b0}}, item.timer_id};
	assign id_addr = id_wide[IW-1:0];
	assign id_ok   = (32'(item.timer_id) < NUM_TIMERS);

	// command decode for start and stop
	always_comb begin
		cmd_status = STATUS_OK;
		set_run    = 1'b0;
		clr_run    = 1'b0;
		unique case (item.cmd)
			CMD_START: begin
				priority if (!id_ok) begin
					cmd_status = STATUS_IDLE;
				end else if (running_q[id_addr]) begin
					cmd_status = STATUS_RUNNING;
				end else begin
					set_run = 1'b1;
				end
			end
			CMD_STOP: begin
				priority if (!id_ok) begin
					cmd_status = STATUS_IDLE;
				end else if (!running_q[id_addr]) begin
					cmd_status = STATUS_IDLE;
				end else begin
					clr_run = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign cnt_cmd = cnt_q + CW'(set_run) - CW'(clr_run);

	// stage 1: subtract elapsed time, saturate at the most negative value
	assign rem_s1    = ram_rdata[RW-1:RELOAD_W];
	assign reload_s1 = ram_rdata[RELOAD_W-1:0];
	assign diff_s1   = {rem_s1[REM_W-1], rem_s1} - {{(REM_W+1-ELAPSED_W){1'b0}}, elapsed_q};
	assign sat_s1    = (diff_s1[REM_W] != diff_s1[REM_W-1]) ? REM_MIN : diff_s1[REM_W-1:0];

	// stage 2: add reload on expiry, write back
	assign neg_s2     = rem_s2[REM_W-1];
	assign sum_s2     = rem_s2 + {{(REM_W-RELOAD_W){1'b0}}, reload_s2};
	assign new_rem_s2 = neg_s2 ? sum_s2 : rem_s2;
	assign live_s2    = v_s2 && running_q[idx_s2];
	assign expire_s2  = live_s2 && neg_s2;
	assign drop_s2    = expire_s2 && oneshot_q[idx_s2];
	assign cnt_drop   = cnt_q - CW'(drop_s2);
	assign xid_wide   = {4'b0, idx_s2};
	assign closing    = (state_q == ST_TICK) && !issue_q && !v_s1 && !v_s2;

	assign ram_we    = (accept && set_run) || live_s2;
	assign ram_waddr = accept ? id_addr : idx_s2;
	assign ram_wdata = accept ?
		{{(REM_W-RELOAD_W){1'b0}}, item.initial_remaining, item.reload_interval} :
		{new_rem_s2, reload_s2};

	mtt_ram #(
		.WIDTH(RW),
		.DEPTH(NUM_TIMERS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_idx_q),
		.rdata (ram_rdata)
	);

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			issue_q   <= 1'b0;
			rd_idx_q  <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			running_q <= '0;
			oneshot_q <= '0;
			cnt_q     <= '0;
			strobe_q  <= 1'b0;
		end else begin
			v_s1     <= issue_q;
			v_s2     <= v_s1;
			// a status word, an expiry word or the closing word
			strobe_q <= (accept && (item.cmd != CMD_TICK)) || expire_s2 || closing;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (item.cmd == CMD_TICK) begin
							state_q  <= ST_TICK;
							issue_q  <= 1'b1;
							rd_idx_q <= '0;
						end else begin
							cnt_q    <= cnt_cmd;
							if (set_run) begin
								running_q[id_addr] <= 1'b1;
								oneshot_q[id_addr] <= item.one_shot;
							end
							if (clr_run) begin
								running_q[id_addr] <= 1'b0;
							end
						end
					end
				end
				ST_TICK: begin
					if (issue_q) begin
						if (rd_idx_q == IW'(NUM_TIMERS - 1)) begin
							issue_q <= 1'b0;
						end else begin
							rd_idx_q <= rd_idx_q + IW'(1);
						end
					end
					if (drop_s2) begin
						running_q[idx_s2] <= 1'b0;
						cnt_q             <= cnt_drop;
					end
					if (closing) begin
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath and result word
	always_ff @(posedge clk) begin
		idx_s1    <= rd_idx_q;
		idx_s2    <= idx_s1;
		rem_s2    <= sat_s1;
		reload_s2 <= reload_s1;
		if (accept && item.cmd == CMD_TICK) begin
			elapsed_q <= item.elapsed_ms;
		end
		priority if (accept) begin
			res_q <= '{kind: KIND_STATUS, status: cmd_status, expired_id: 4'd0,
				active_count: cnt_cmd[4:0], last: 1'b1};
		end else if (expire_s2) begin
			res_q <= '{kind: KIND_EXPIRY, status: STATUS_OK, expired_id: xid_wide[3:0],
				active_count: cnt_drop[4:0], last: 1'b0};
		end else if (closing) begin
			res_q <= '{kind: KIND_DONE, status: STATUS_OK, expired_id: 4'd0,
				active_count: cnt_q[4:0], last: 1'b1};
		end else begin
			res_q <= res_q;
		end
	end

	assign strobe = strobe_q;
	assign result = res_q;

`ifndef NO_ASSERTIONS
	a_count_matches_flags: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) == $countones(running_q))
		else $error("active count disagrees with running flags");

	a_pipe_only_in_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 || v_s2) |-> (state_q == ST_TICK))
		else $error("scan stage valid outside tick");

	a_done_after_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.kind == KIND_DONE) |-> $past(state_q == ST_TICK))
		else $error("closing word without a tick");

	a_expiry_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && result.kind == KIND_EXPIRY) |-> (busy && !result.last))
		else $error("expiry word outside a tick or marked last");
`endif

endmodule

FILE: verif/mtt_checker.sv
// result checker for the timer table: watches the command and result channels,
// predicts every word from its own copy of the table and compares in order
// depends on mtt_pkg
module mtt_checker #(
	parameter int NUM_TIMERS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  mtt_pkg::item_t   item,
	input  logic             strobe,
	input  mtt_pkg::result_t result,
	output int               errors,
	output int               pending,
	output int               words_seen,
	output int               expiries_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	import mtt_pkg::*;

	logic                timer_on     [NUM_TIMERS];
	logic                timer_once   [NUM_TIMERS];
	logic [REM_W-1:0]    timer_left   [NUM_TIMERS];
	logic [RELOAD_W-1:0] timer_reload [NUM_TIMERS];

	result_t due_words[$];
	result_t want;
	int      mismatch_count;
	int      word_count;
	int      expiry_count;

	function automatic logic [4:0] running_total();
		int n;
		n = 0;
		for (int i = 0; i < NUM_TIMERS; i++)
			if (timer_on[i])
				n++;
		return n[4:0];
	endfunction

	task automatic queue_word(logic [1:0] kind, logic [1:0] status, logic [3:0] id,
			logic [4:0] count, logic last);
		result_t w;
		w.kind         = kind;
		w.status       = status;
		w.expired_id   = id;
		w.active_count = count;
		w.last         = last;
		due_words.push_back(w);
	endtask

	// updates the table copy for one accepted command and queues its words
	task automatic apply_command(item_t w);
		logic signed [REM_W:0] diff;
		logic [REM_W-1:0]      left;
		logic [1:0]            st;
		if (w.cmd == CMD_TICK) begin
			for (int i = 0; i < NUM_TIMERS; i++) begin
				if (timer_on[i]) begin
					diff = $signed({timer_left[i][REM_W-1], timer_left[i]})
						- $signed({{(REM_W+1-ELAPSED_W){1'b0}}, w.elapsed_ms});
					// saturate at the most negative remaining time
					if (diff < $signed({1'b1, REM_MIN}))
						left = REM_MIN;
					else
						left = diff[REM_W-1:0];
					if (left[REM_W-1]) begin
						if (timer_once[i])
							timer_on[i] = 1'b0;
						left = left + {{(REM_W-RELOAD_W){1'b0}}, timer_reload[i]};
						timer_left[i] = left;
						queue_word(KIND_EXPIRY, STATUS_OK, 4'(i), running_total(), 1'b0);
					end else begin
						timer_left[i] = left;
					end
				end
			end
			queue_word(KIND_DONE, STATUS_OK, 4'd0, running_total(), 1'b1);
		end else begin
			st = STATUS_OK;
			if (w.cmd == CMD_START || w.cmd == CMD_STOP) begin
				if (w.timer_id >= NUM_TIMERS) begin
					st = STATUS_IDLE;
				end else if (w.cmd == CMD_START) begin
					if (timer_on[w.timer_id]) begin
						st = STATUS_RUNNING;
					end else begin
						timer_on[w.timer_id]     = 1'b1;
						timer_once[w.timer_id]   = w.one_shot;
						timer_left[w.timer_id]   = {{(REM_W-RELOAD_W){1'b0}}, w.initial_remaining};
						timer_reload[w.timer_id] = w.reload_interval;
					end
				end else if (!timer_on[w.timer_id]) begin
					st = STATUS_IDLE;
				end else begin
					timer_on[w.timer_id] = 1'b0;
				end
			end
			queue_word(KIND_STATUS, st, 4'd0, running_total(), 1'b1);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_TIMERS; i++) begin
				timer_on[i]     = 1'b0;
				timer_once[i]   = 1'b0;
				timer_left[i]   = '0;
				timer_reload[i] = '0;
			end
			due_words.delete();
			mismatch_count = 0;
			word_count     = 0;
			expiry_count   = 0;
		end else begin
			if (start && !busy)
				apply_command(item);
			if (strobe) begin
				if (due_words.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: unexpected word kind %0d status %0d id %0d count %0d last %0d",
							$realtime, result.kind, result.status, result.expired_id,
							result.active_count, result.last);
				end else begin
					want = due_words.pop_front();
					word_count++;
					if (want.kind == KIND_EXPIRY)
						expiry_count++;
					if (result.kind !== want.kind || result.status !== want.status
							|| result.expired_id !== want.expired_id
							|| result.active_count !== want.active_count
							|| result.last !== want.last) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display({"%0t: word %0d expected kind %0d status %0d id %0d count %0d",
								" last %0d, got kind %0d status %0d id %0d count %0d last %0d"},
								$realtime, word_count, want.kind, want.status, want.expired_id,
								want.active_count, want.last, result.kind, result.status,
								result.expired_id, result.active_count, result.last);
					end
				end
			end
		end
		errors        <= mismatch_count;
		pending       <= due_words.size();
		words_seen    <= word_count;
		expiries_seen <= expiry_count;
	end

endmodule

FILE: verif/tb_top.sv
// testbench top for the timer table: clock, reset and command stimulus
// depends on mtt_pkg, multi_timer_table and mtt_checker
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mtt_pkg::*;

	localparam int         NUM_TIMERS   = 16;
	localparam logic [1:0] CMD_UNUSED   = 2'd3;
	localparam int         RANDOM_WORDS = 395;
	localparam int         DRAIN_CYCLES = 3 * (NUM_TIMERS + 4);

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	item_t   item;
	logic    strobe;
	result_t result;

	int errors;
	int pending;
	int words_seen;
	int expiries_seen;
	int commands_sent;
	bit no_gaps;

	multi_timer_table #(.NUM_TIMERS(NUM_TIMERS)) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.strobe (strobe),
		.result (result)
	);

	mtt_checker #(.NUM_TIMERS(NUM_TIMERS)) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.item          (item),
		.strobe        (strobe),
		.result        (result),
		.errors        (errors),
		.pending       (pending),
		.words_seen    (words_seen),
		.expiries_seen (expiries_seen)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("multi_timer_table: mismatch");
		$finish;
	end

	function automatic item_t make_word(logic [1:0] cmd, logic [3:0] id,
			logic [RELOAD_W-1:0] init, logic [RELOAD_W-1:0] reload, logic once,
			logic [ELAPSED_W-1:0] elapsed);
		item_t w;
		w.cmd               = cmd;
		w.timer_id          = id;
		w.initial_remaining = init;
		w.reload_interval   = reload;
		w.one_shot          = once;
		w.elapsed_ms        = elapsed;
		return w;
	endfunction

	// holds the word on the bus until an edge sees busy low
	task automatic send_word(item_t w);
		start <= 1'b1;
		item  <= w;
		do
			@(posedge clk);
		while (busy);
		commands_sent++;
	endtask

	task automatic maybe_gap();
		if (!no_gaps && $urandom_range(99) < 32) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 24)) @(posedge clk);
		end
	endtask

	function automatic item_t random_word();
		item_t       w;
		int unsigned pick;
		w.cmd               = 2'($urandom);
		w.timer_id          = 4'($urandom);
		w.initial_remaining = RELOAD_W'($urandom);
		w.reload_interval   = RELOAD_W'($urandom);
		w.one_shot          = 1'($urandom);
		w.elapsed_ms        = ELAPSED_W'($urandom);
		pick = $urandom_range(99);
		if (pick < 45) begin
			w.cmd = CMD_START;
			if ($urandom_range(9) != 0)
				w.initial_remaining = RELOAD_W'($urandom_range(3000));
			if ($urandom_range(9) != 0)
				w.reload_interval = RELOAD_W'($urandom_range(2000));
		end else if (pick < 60) begin
			w.cmd = CMD_STOP;
		end else if (pick < 95) begin
			w.cmd = CMD_TICK;
			pick = $urandom_range(99);
			if (pick < 5)
				w.elapsed_ms = '0;
			else if (pick >= 13)
				w.elapsed_ms = ELAPSED_W'($urandom_range(1500));
		end else begin
			w.cmd = CMD_UNUSED;
		end
		return w;
	endfunction

	initial begin
		arst_n        = 1'b0;
		start         = 1'b0;
		item          = '0;
		no_gaps       = 1'b0;
		commands_sent = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one-shot at zero: no expiry on a zero tick, expiry and free on the next
		send_word(make_word(CMD_START, 4'd0, '0, '0, 1'b1, '0));
		send_word(make_word(CMD_TICK, 4'd0, '0, '0, 1'b0, 16'd0));
		maybe_gap();
		send_word(make_word(CMD_TICK, 4'd0, '0, '0, 1'b0, 16'd1));
		send_word(make_word(CMD_START, 4'd15, '1, '1, 1'b0, '0));
		send_word(make_word(CMD_START, 4'd15, '1, '1, 1'b0, '0));
		maybe_gap();
		send_word(make_word(CMD_STOP, 4'd3, '0, '0, 1'b0, '0));
		// periodic with no interval stays negative and expires on a zero tick too
		send_word(make_word(CMD_START, 4'd3, 31'd5, '0, 1'b0, '0));
		send_word(make_word(CMD_TICK, 4'd0, '0, '0, 1'b0, '1));
		send_word(make_word(CMD_TICK, 4'd0, '0, '0, 1'b0, 16'd0));
		maybe_gap();
		send_word(make_word(CMD_STOP, 4'd3, '0, '0, 1'b0, '0));
		send_word(make_word(CMD_START, 4'd3, 31'd100, 31'd7, 1'b1, '0));
		send_word(make_word(CMD_UNUSED, 4'd15, '1, '1, 1'b1, '1));
		send_word(make_word(CMD_STOP, 4'd15, '0, '0, 1'b0, '0));
		maybe_gap();
		send_word(make_word(CMD_STOP, 4'd3, '0, '0, 1'b0, '0));
		send_word(make_word(CMD_TICK, 4'd0, '0, '0, 1'b0, '1));

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			no_gaps = (i >= 150 && i < 250);
			send_word(random_word());
			maybe_gap();
		end
		start <= 1'b0;

		for (int g = 0; g < 4000 && pending != 0; g++)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d commands; checked %0d words, %0d of them timer expiries",
			commands_sent, words_seen, expiries_seen);
		if (errors == 0 && pending == 0)
			$display("multi_timer_table: match");
		else
			$display("multi_timer_table: mismatch");
		$finish;
	end

endmodule

FILE: multi_timer_table.f
design/mtt_pkg.sv
design/mtt_ram.sv
design/multi_timer_table.sv
verif/mtt_checker.sv
verif/tb_top.sv
